>>> rtl/core/bot_block_command_sequencer_top_macros.svh
// Assertion macros shared by the sequencer checker.
// Each macro expects i_clk in scope; the two that are off during reset also need i_rst_n.
`ifndef BOT_BLOCK_COMMAND_SEQUENCER_TOP_MACROS_SVH
`define BOT_BLOCK_COMMAND_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, off during reset
`define BOT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset
`define BOT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers reset itself
`define BOT_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bot_seq_pkg.sv
// Shared types and constants of the bulk-only command sequencer.
// No dependencies; used by every module of the block.
package bot_seq_pkg;

    localparam int QueueDepth = 2;

    localparam int LBA_W  = 32;
    localparam int TAG_W  = 32;
    localparam int LEN_W  = 13;
    localparam int CNT_W  = 16;
    localparam int CODE_W = 8;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 112;

    // Command selector codes on the slave tuser
    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_STATUS = 2'd2;

    // Configuration register indexes
    localparam logic CFG_PRESENT = 1'b0;
    localparam logic CFG_SECTOR  = 1'b1;

    localparam logic [31:0]      CSW_SIGNATURE  = 32'h5342_5355;
    localparam logic [7:0]       OP_READ10      = 8'h28;
    localparam logic [7:0]       OP_WRITE10     = 8'h2A;
    localparam logic [7:0]       DIR_IN         = 8'h80;
    localparam logic [7:0]       DIR_OUT        = 8'h00;
    localparam logic [LEN_W-1:0] SECTOR_DEFAULT = 13'd512;

    typedef enum logic [2:0] {
        KIND_ISSUED     = 3'd0,
        KIND_DONE       = 3'd1,
        KIND_INVALID    = 3'd2,
        KIND_ABSENT     = 3'd3,
        KIND_STATUS_ERR = 3'd4,
        KIND_BUSY       = 3'd5,
        KIND_UNEXPECTED = 3'd6
    } t_kind;

    // Classified item as it waits between front and back
    typedef struct packed {
        logic              is_status;
        logic              is_write;
        logic              total_zero;
        logic              status_ok;   // signature and status byte good
        logic [LBA_W-1:0]  start;
        logic [31:0]       total;
        logic [TAG_W-1:0]  tag;
    } t_seq_entry;

    typedef struct packed {
        logic              present;
        logic [LEN_W-1:0]  blk_bytes;
    } t_seq_cfg;

    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [LBA_W-1:0]  lba;
        logic [7:0]        op;
        logic [7:0]        dir;
        logic [LEN_W-1:0]  len;
        logic [TAG_W-1:0]  tag;
    } t_seq_desc;

endpackage

>>> rtl/core/bot_block_command_sequencer_top.sv
// An accepted item is written into a queue entry, then popped into the result
// register, from which it is offered; output stalls can hold it in between.
// The back end takes one item per cycle while the result register is free or
// draining; the queue absorbs output stalls.
// Reset (synchronous, active low) empties the queue and result register,
// clears tag, busy and block state, and sets device_present 0, sector length 512.
module bot_block_command_sequencer_top #(
    parameter int QDEPTH = bot_seq_pkg::QueueDepth
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [bot_seq_pkg::LEN_W-1:0]      i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // start_block[31:0], block_total[63:32], status_signature[95:64],
    // status_tag[127:96], status_code[135:128]
    input  logic [bot_seq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // command[1:0]
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // wrapper_tag[31:0], transfer_length[44:32], direction_flag[52:45],
    // scsi_opcode[60:53], block_address[92:61], block_count[108:93], zero pad
    output logic [bot_seq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // result_kind[2:0]
    output logic [2:0]                         m_axis_tuser
);
    import bot_seq_pkg::*;

    t_seq_cfg    r_cfg;
    logic        w_push, w_q_ready, w_q_valid, w_pop;
    t_seq_entry  w_in_entry, w_q_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.present   <= 1'b0;
            r_cfg.blk_bytes <= SECTOR_DEFAULT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PRESENT: r_cfg.present   <= i_cfg_data[0];
                CFG_SECTOR:  r_cfg.blk_bytes <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    bot_seq_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_ready     (w_q_ready),
        .o_push        (w_push),
        .o_entry       (w_in_entry)
    );

    bot_seq_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_in_entry),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    bot_seq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (w_q_valid),
        .i_entry       (w_q_entry),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> rtl/core/bot_seq_front.sv
// Front end: unpacks an incoming request or status word and classifies it.
// Depends on bot_seq_pkg.
module bot_seq_front (
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [bot_seq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]                         s_axis_tuser,
    input  logic                               i_q_ready,
    output logic                               o_push,
    output bot_seq_pkg::t_seq_entry            o_entry
);
    import bot_seq_pkg::*;

    logic [31:0]       w_sig;
    logic [CODE_W-1:0] w_code;
    logic              w_known;

    assign w_sig  = s_axis_tdata[95:64];
    assign w_code = s_axis_tdata[135:128];

    always_comb begin
        unique case (s_axis_tuser)
            CMD_READ, CMD_WRITE, CMD_STATUS: w_known = 1'b1;
            default:                         w_known = 1'b0;
        endcase
    end

    // Unknown selectors are taken and dropped
    assign s_axis_tready = i_q_ready;
    assign o_push        = s_axis_tvalid && i_q_ready && w_known;

    always_comb begin
        o_entry.is_status  = (s_axis_tuser == CMD_STATUS);
        o_entry.is_write   = (s_axis_tuser == CMD_WRITE);
        o_entry.start      = s_axis_tdata[31:0];
        o_entry.total      = s_axis_tdata[63:32];
        o_entry.tag        = s_axis_tdata[127:96];
        o_entry.total_zero = (o_entry.total == 32'd0);
        o_entry.status_ok  = (w_sig == CSW_SIGNATURE) && (w_code == '0);
    end

endmodule

>>> rtl/core/bot_seq_queue.sv
// Short queue of classified items between front and back.
// Depends on bot_seq_pkg.
module bot_seq_queue #(
    parameter int DEPTH = bot_seq_pkg::QueueDepth
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  bot_seq_pkg::t_seq_entry  i_entry,
    output logic                     o_ready,
    input  logic                     i_pop,
    output logic                     o_valid,
    output bot_seq_pkg::t_seq_entry  o_entry
);
    import bot_seq_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_seq_entry        r_mem [DEPTH];
    logic [PW-1:0]     r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              w_push, w_pop;

    assign o_ready = (r_cnt != FULL);
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + PW'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

>>> rtl/core/bot_seq_back.sv
// Back end: carries out classified items against the transfer state and
// drives the result register. Depends on bot_seq_pkg.
module bot_seq_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bot_seq_pkg::t_seq_cfg              i_cfg,
    input  logic                               i_q_valid,
    input  bot_seq_pkg::t_seq_entry            i_entry,
    output logic                               o_pop,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [bot_seq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic [2:0]                         m_axis_tuser
);
    import bot_seq_pkg::*;

    localparam int DESC_W = $bits(t_seq_desc);

    logic [TAG_W-1:0]  r_tag, n_tag;
    logic              r_busy, n_busy;
    logic              r_write, n_write;
    logic [LBA_W-1:0]  r_next, n_next;
    logic [31:0]       r_left, n_left;

    logic              r_out_valid;
    t_kind             r_kind, n_kind;
    t_seq_desc         r_desc, n_desc;
    logic              w_issue;
    logic [TAG_W-1:0]  w_tag_inc;

    // Take an item whenever the result register is free or draining
    assign o_pop     = i_q_valid && (!r_out_valid || m_axis_tready);
    assign w_tag_inc = r_tag + TAG_W'(1);

    always_comb begin
        n_tag   = r_tag;
        n_busy  = r_busy;
        n_write = r_write;
        n_next  = r_next;
        n_left  = r_left;
        n_kind  = KIND_ISSUED;
        w_issue = 1'b0;
        if (!i_entry.is_status) begin
            if (r_busy) begin
                n_kind = KIND_BUSY;
            end else if (i_entry.total_zero) begin
                n_kind = KIND_INVALID;
            end else if (!i_cfg.present) begin
                n_kind = KIND_ABSENT;
            end else begin
                n_busy  = 1'b1;
                n_write = i_entry.is_write;
                n_next  = i_entry.start;
                n_left  = i_entry.total;
                w_issue = 1'b1;
            end
        end else begin
            if (!r_busy) begin
                n_kind = KIND_UNEXPECTED;
            end else if (!i_entry.status_ok || (i_entry.tag != r_tag)) begin
                n_kind = KIND_STATUS_ERR;
                n_busy = 1'b0;
                n_left = '0;
            end else begin
                n_next = r_next + LBA_W'(1);
                n_left = r_left - 32'd1;
                if (r_left == 32'd1) begin
                    n_kind = KIND_DONE;
                    n_busy = 1'b0;
                end else begin
                    w_issue = 1'b1;
                end
            end
        end
        n_desc = DESC_W'(0);
        if (w_issue) begin
            n_tag       = w_tag_inc;
            n_desc.tag  = w_tag_inc;
            n_desc.len  = i_cfg.blk_bytes;
            n_desc.dir  = n_write ? DIR_OUT : DIR_IN;
            n_desc.op   = n_write ? OP_WRITE10 : OP_READ10;
            n_desc.lba  = n_next;
            n_desc.cnt  = CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag       <= '0;
            r_busy      <= 1'b0;
            r_write     <= 1'b0;
            r_next      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_tag   <= n_tag;
                r_busy  <= n_busy;
                r_write <= n_write;
                r_next  <= n_next;
                r_left  <= n_left;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= n_kind;
            r_desc <= n_desc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tdata  = M_TDATA_W'(r_desc);

endmodule

>>> rtl/core/bot_seq_checker.sv
// Port-level checks of the sequencer, bound to the top level.
// Depends on bot_seq_pkg and bot_block_command_sequencer_top_macros.svh.
`include "bot_block_command_sequencer_top_macros.svh"

module bot_seq_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [bot_seq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic [2:0]                         m_axis_tuser
);
    import bot_seq_pkg::*;

    logic w_issued;
    assign w_issued = (m_axis_tuser == KIND_ISSUED);

    // Reset leaves no result on offer
    `BOT_ASSERT_ALWAYS_NEXT(a_rst_quiet, !i_rst_n, !m_axis_tvalid, "result valid after reset")

    // A stalled result holds its payload
    `BOT_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // Only descriptors carry payload
    `BOT_ASSERT_NOW(a_zero_payload, m_axis_tvalid && !w_issued, m_axis_tdata == '0, "non-descriptor result with payload")

    // Every descriptor moves exactly one block in a known direction
    `BOT_ASSERT_NOW(a_desc_shape, m_axis_tvalid && w_issued, (m_axis_tdata[108:93] == 16'd1) && ((m_axis_tdata[52:45] == DIR_IN && m_axis_tdata[60:53] == OP_READ10) || (m_axis_tdata[52:45] == DIR_OUT && m_axis_tdata[60:53] == OP_WRITE10)), "malformed descriptor")

endmodule

bind bot_block_command_sequencer_top bot_seq_checker u_bot_seq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> test/tb_top.sv
// Self-checking bench for the bulk-only block command sequencer.
// Drives request/status items and checks every result against an in-bench model.
// Depends on bot_seq_pkg and bot_block_command_sequencer_top.
`timescale 1ns / 100ps

module tb_top;
    import bot_seq_pkg::*;

    localparam logic [1:0]  CMD_IGNORED   = 2'd3;
    localparam logic [31:0] CBW_SIGNATURE = 32'h4342_5355;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          CYCLE_LIMIT   = 400000;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] start;
        logic [31:0] total;
        logic [31:0] sig;
        logic [31:0] tag;
        logic [7:0]  code;
    } t_seq_item;

    typedef struct {
        t_kind             kind;
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
        logic [7:0]        dir;
        logic [7:0]        op;
        logic [LBA_W-1:0]  lba;
        logic [CNT_W-1:0]  cnt;
    } t_seq_result;

    typedef struct {
        t_seq_item item;
        bit        typed;
        t_kind     kind;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_idx = CFG_PRESENT;
    logic [LEN_W-1:0]      i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = CMD_READ;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [2:0]            m_axis_tuser;

    // Sequencer state as the bench predicts it
    logic [TAG_W-1:0]  seq_tag = '0;
    logic              seq_busy = 1'b0;
    logic              seq_write = 1'b0;
    logic [LBA_W-1:0]  seq_lba = '0;
    logic [31:0]       seq_left = '0;
    logic              cfg_present = 1'b0;
    logic [LEN_W-1:0]  cfg_sector = SECTOR_DEFAULT;

    t_seq_result result_q[$];
    t_stim_row   stim_rows[$];

    int send_idle_pct = 13;
    int recv_stall_pct = 79;
    int mismatches = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int kind_seen[8];
    int cycle_count = 0;

    bot_block_command_sequencer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, result_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_seq_result blank_result(input t_kind k);
        t_seq_result r;
        r.kind = k;
        r.tag  = '0;
        r.len  = '0;
        r.dir  = '0;
        r.op   = '0;
        r.lba  = '0;
        r.cnt  = '0;
        return r;
    endfunction

    function automatic t_seq_result issue_descriptor();
        t_seq_result r;
        seq_tag = seq_tag + 1;
        r.kind = KIND_ISSUED;
        r.tag  = seq_tag;
        r.len  = cfg_sector;
        r.dir  = seq_write ? DIR_OUT : DIR_IN;
        r.op   = seq_write ? OP_WRITE10 : OP_READ10;
        r.lba  = seq_lba;
        r.cnt  = 16'd1;
        return r;
    endfunction

    // Advance the predicted state by one item; return 1 when a result follows
    function automatic bit predict_sequencer(input t_seq_item it, output t_seq_result res);
        res = blank_result(KIND_DONE);
        if (it.cmd == CMD_READ || it.cmd == CMD_WRITE) begin
            if (seq_busy) begin
                res = blank_result(KIND_BUSY);
            end else if (it.total == 0) begin
                res = blank_result(KIND_INVALID);
            end else if (!cfg_present) begin
                res = blank_result(KIND_ABSENT);
            end else begin
                seq_busy  = 1'b1;
                seq_write = (it.cmd == CMD_WRITE);
                seq_lba   = it.start;
                seq_left  = it.total;
                res = issue_descriptor();
            end
            return 1'b1;
        end
        if (it.cmd == CMD_STATUS) begin
            if (!seq_busy) begin
                res = blank_result(KIND_UNEXPECTED);
            end else if (it.sig != CSW_SIGNATURE || it.tag != seq_tag || it.code != 0) begin
                seq_busy = 1'b0;
                seq_left = '0;
                res = blank_result(KIND_STATUS_ERR);
            end else begin
                seq_lba  = seq_lba + 1;
                seq_left = seq_left - 1;
                if (seq_left == 0) begin
                    seq_busy = 1'b0;
                    res = blank_result(KIND_DONE);
                end else begin
                    res = issue_descriptor();
                end
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : result_monitor
        t_seq_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                $error("result_kind: expected none, got 0x%0h", m_axis_tuser);
                mismatches++;
            end else begin
                want = result_q.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(m_axis_tuser));
                check_field("wrapper_tag", want.tag, m_axis_tdata[31:0]);
                check_field("transfer_length", 32'(want.len), 32'(m_axis_tdata[44:32]));
                check_field("direction_flag", 32'(want.dir), 32'(m_axis_tdata[52:45]));
                check_field("scsi_opcode", 32'(want.op), 32'(m_axis_tdata[60:53]));
                check_field("block_address", want.lba, m_axis_tdata[92:61]);
                check_field("block_count", 32'(want.cnt), 32'(m_axis_tdata[108:93]));
                check_field("zero_pad", 32'd0, 32'(m_axis_tdata[111:109]));
                kind_seen[m_axis_tuser]++;
                results_checked++;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one item and hold it until the sequencer takes it
    task automatic send_item(input t_seq_item it, input bit typed, input t_kind kind);
        t_seq_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.code, it.tag, it.sig, it.total, it.start};
        s_axis_tuser  <= it.cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_accepted++;
        if (predict_sequencer(it, res)) begin
            if (typed) res = blank_result(kind);
            result_q.push_back(res);
        end
    endtask

    // Registers change only with the sequencer drained and idle
    task automatic write_sequencer_regs(input logic present, input logic [LEN_W-1:0] sector);
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PRESENT;
        i_cfg_data <= {{(LEN_W-1){1'b0}}, present};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SECTOR;
        i_cfg_data <= sector;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_present = present;
        cfg_sector  = sector;
    endtask

    function automatic void add_row(input logic [1:0] cmd, input logic [31:0] start,
                                    input logic [31:0] total, input logic [31:0] sig,
                                    input logic [31:0] tag, input logic [7:0] code,
                                    input bit typed, input t_kind kind);
        t_stim_row row;
        row.item.cmd   = cmd;
        row.item.start = start;
        row.item.total = total;
        row.item.sig   = sig;
        row.item.tag   = tag;
        row.item.code  = code;
        row.typed      = typed;
        row.kind       = kind;
        stim_rows.push_back(row);
    endfunction

    task automatic run_stim_table();
        foreach (stim_rows[i]) send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].kind);
        stim_rows.delete();
    endtask

    // Mostly well-formed request/status runs, with broken and stray items mixed in
    function automatic t_seq_item make_traffic_item();
        t_seq_item it;
        int pick;
        int span;
        it.cmd   = CMD_STATUS;
        it.start = $urandom;
        it.total = $urandom;
        it.sig   = $urandom;
        it.tag   = $urandom;
        it.code  = 8'($urandom);
        pick = $urandom_range(99);
        if (!seq_busy) begin
            if (pick < 75) begin
                it.cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
                span = $urandom_range(99);
                if (span < 60) it.total = $urandom_range(1, 4);
                else if (span < 72) it.total = '0;
                else if (span < 84) it.total = $urandom_range(5, 12);
                if ($urandom_range(4) == 0) it.start = 32'hFFFF_FFFF - $urandom_range(3);
            end else if (pick < 88) begin
                if ($urandom_range(1)) begin
                    it.sig  = CSW_SIGNATURE;
                    it.tag  = seq_tag;
                    it.code = '0;
                end
            end else begin
                it.cmd = CMD_IGNORED;
            end
        end else begin
            if (pick < 96) begin
                it.sig  = CSW_SIGNATURE;
                it.tag  = seq_tag;
                it.code = '0;
            end
            if (pick >= 80 && pick < 88) begin
                case ($urandom_range(2))
                    0: it.sig = $urandom_range(1) ? CBW_SIGNATURE : $urandom;
                    1: it.tag = seq_tag ^ (32'd1 << $urandom_range(31));
                    default: it.code = 8'($urandom_range(1, 255));
                endcase
            end else if (pick >= 88 && pick < 96) begin
                it.cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
            end else if (pick >= 96) begin
                it.cmd = CMD_IGNORED;
            end
        end
        return it;
    endfunction

    task automatic run_traffic(input logic present, input logic [LEN_W-1:0] sector,
                               input int snd_pct, input int rcv_pct, input int count);
        t_seq_item it;
        int sent;
        sent = 0;
        write_sequencer_regs(present, sector);
        send_idle_pct  = snd_pct;
        recv_stall_pct = rcv_pct;
        while (sent < count) begin
            it = make_traffic_item();
            send_item(it, 1'b0, KIND_ISSUED);
            if (it.cmd != CMD_IGNORED) sent++;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset: device absent, sector size at default
        add_row(CMD_READ,   32'd0,        32'd0,        32'd0,         32'd0,        8'd0,
                1'b1, KIND_INVALID);
        add_row(CMD_WRITE,  32'hFFFFFFFF, 32'd0,        32'd0,         32'd0,        8'd0,
                1'b1, KIND_INVALID);
        add_row(CMD_READ,   32'd5,        32'd1,        32'd0,         32'd0,        8'd0,
                1'b1, KIND_ABSENT);
        add_row(CMD_WRITE,  32'd0,        32'hFFFFFFFF, 32'd0,         32'd0,        8'd0,
                1'b1, KIND_ABSENT);
        add_row(CMD_STATUS, 32'd0,        32'd0,        CSW_SIGNATURE, 32'd0,        8'd0,
                1'b1, KIND_UNEXPECTED);
        add_row(CMD_STATUS, 32'd0,        32'd0,        32'hFFFFFFFF,  32'hFFFFFFFF, 8'hFF,
                1'b1, KIND_UNEXPECTED);
        add_row(CMD_IGNORED, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF,
                1'b0, KIND_ISSUED);
        run_stim_table();

        write_sequencer_regs(1'b1, 13'd4096);
        // Two-block read that wraps the block address
        add_row(CMD_READ,   32'hFFFFFFFF, 32'd2,        32'd0,         32'd0,        8'd0,
                1'b0, KIND_ISSUED);
        add_row(CMD_READ,   32'd1,        32'd1,        32'd0,         32'd0,        8'd0,
                1'b1, KIND_BUSY);
        add_row(CMD_WRITE,  32'd1,        32'd0,        32'd0,         32'd0,        8'd0,
                1'b1, KIND_BUSY);
        add_row(CMD_STATUS, 32'd0,        32'd0,        CSW_SIGNATURE, 32'd1,        8'd0,
                1'b0, KIND_ISSUED);
        add_row(CMD_STATUS, 32'd0,        32'd0,        CSW_SIGNATURE, 32'd2,        8'd0,
                1'b1, KIND_DONE);
        // Each way a status word can fail
        add_row(CMD_WRITE,  32'd0,        32'hFFFFFFFF, 32'd0,         32'd0,        8'd0,
                1'b0, KIND_ISSUED);
        add_row(CMD_STATUS, 32'd0,        32'd0,        CBW_SIGNATURE, 32'd3,        8'd0,
                1'b1, KIND_STATUS_ERR);
        add_row(CMD_WRITE,  32'd100,      32'd1,        32'd0,         32'd0,        8'd0,
                1'b0, KIND_ISSUED);
        add_row(CMD_STATUS, 32'd0,        32'd0,        CSW_SIGNATURE, 32'd4,        8'hFF,
                1'b1, KIND_STATUS_ERR);
        add_row(CMD_READ,   32'h12345678, 32'd1,        32'd0,         32'd0,        8'd0,
                1'b0, KIND_ISSUED);
        add_row(CMD_STATUS, 32'd0,        32'd0,        CSW_SIGNATURE, 32'd4,        8'd0,
                1'b1, KIND_STATUS_ERR);
        // Three-block read with an ignored command in the middle
        add_row(CMD_READ,   32'd7,        32'd3,        32'd0,         32'd0,        8'd0,
                1'b0, KIND_ISSUED);
        add_row(CMD_STATUS, 32'd0,        32'd0,        CSW_SIGNATURE, 32'd6,        8'd0,
                1'b0, KIND_ISSUED);
        add_row(CMD_IGNORED, 32'd0,       32'd0,        32'd0,         32'd0,        8'd0,
                1'b0, KIND_ISSUED);
        add_row(CMD_STATUS, 32'd0,        32'd0,        CSW_SIGNATURE, 32'd7,        8'd0,
                1'b0, KIND_ISSUED);
        add_row(CMD_STATUS, 32'd0,        32'd0,        CSW_SIGNATURE, 32'd8,        8'd0,
                1'b1, KIND_DONE);
        add_row(CMD_STATUS, 32'd0,        32'd0,        CSW_SIGNATURE, 32'd8,        8'd0,
                1'b1, KIND_UNEXPECTED);
        run_stim_table();

        run_traffic(1'b1, 13'd1,    13, 79, 75);
        run_traffic(1'b1, 13'd4096, 13, 79, 75);
        run_traffic(1'b1, 13'd0,    79, 13, 75);
        run_traffic(1'b0, 13'd8191, 79, 13, 30);
        run_traffic(1'b1, 13'd512,  0,  0,  75);
        run_traffic(1'b1, 13'd2731, 0,  0,  75);

        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d items accepted, %0d results checked in %0d cycles",
                 items_accepted, results_checked, cycle_count);
        $display("  descriptors %0d, done %0d, status errors %0d, busy %0d, rejects %0d",
                 kind_seen[KIND_ISSUED], kind_seen[KIND_DONE], kind_seen[KIND_STATUS_ERR],
                 kind_seen[KIND_BUSY], kind_seen[KIND_INVALID] + kind_seen[KIND_ABSENT]
                 + kind_seen[KIND_UNEXPECTED]);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
